>>> src/prs_pkg.sv
// Shared types and codes of the ping round-trip statistics block.
`timescale 1ns / 1ps
package prs_pkg;

	localparam logic [1:0] CMD_SEND  = 2'd0;
	localparam logic [1:0] CMD_RECV  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic CFG_WINDOW_SIZE = 1'b0;
	localparam logic CFG_EXPIRE_MS   = 1'b1;

	localparam logic [15:0] EXPIRE_RESET = 16'd1000;
	localparam logic [4:0]  WINDOW_RESET = 5'd16;

	typedef struct packed {
		logic [31:0] rtt_sum;
		logic [31:0] sq_sum;
		logic [31:0] lost;
	} hist_ent_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEND_RD,
		S_SEND_CHK,
		S_SEND_PUSH,
		S_RECV_RD,
		S_RECV_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RECV_EVAL,
		S_RECV_UPD,
		S_HIST_RD,
		S_CLEAR,
		S_DONE
	} state_t;

endpackage

>>> src/prs_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module prs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> src/ping_roundtrip_statistics.sv
// Ping round-trip statistics: top level with control sequencer and counters.
`timescale 1ns / 1ps
// A send first drops expired pending entries from the head, a receive searches the queue
//   and shifts later entries down over a match, a clear empties the queue; the walk goes
//   entry by entry through the read port of the pending-time RAM.
// Throughput: one transaction at a time; the next is taken in the cycle after its result
//   enters the output register, while that result may still wait.
// Reset: arst_n or a window_size write clears queue, history (one zero entry) and counters.
module ping_roundtrip_statistics #(
	parameter int WINDOW_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] send_time,
	input  logic [31:0] recv_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        matched,
	output logic [31:0] sent_total,
	output logic [31:0] received_total,
	output logic [31:0] lost_total,
	output logic [15:0] rtt_min_ms,
	output logic [15:0] rtt_max_ms,
	output logic [63:0] rtt_sum_ms,
	output logic [63:0] rtt_sq_sum,
	output logic [31:0] win_rtt_sum,
	output logic [31:0] win_rtt_sq_sum,
	output logic [31:0] win_lost,
	output logic [4:0]  win_entries
);
	import prs_pkg::*;

	// Counts hold up to WINDOW_MAX+1; ring pointers index the two RAMs.
	localparam int HD  = WINDOW_MAX + 1;
	localparam int CW  = $clog2(WINDOW_MAX + 2);
	localparam int CW1 = CW + 1;
	localparam int PAW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int HAW = $clog2(HD);
	localparam logic [CW1-1:0] PDEPTH = CW1'(WINDOW_MAX);
	localparam logic [CW1-1:0] HDEPTH = CW1'(HD);
	localparam logic [CW-1:0]  ONE    = CW'(1);
	localparam logic [CW-1:0]  TWO    = CW'(2);

	function automatic logic [PAW-1:0] pidx(input logic [PAW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW1-1:0] s;
		s = CW1'(base) + CW1'(off);
		if (s >= PDEPTH) s = s - PDEPTH;
		return s[PAW-1:0];
	endfunction

	function automatic logic [HAW-1:0] hidx(input logic [HAW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW1-1:0] s;
		s = CW1'(base) + CW1'(off);
		if (s >= HDEPTH) s = s - HDEPTH;
		return s[HAW-1:0];
	endfunction

	function automatic logic [CW-1:0] clamp_cap(input logic [4:0] ws);
		logic [CW-1:0] c;
		if (ws == 5'd0) c = ONE;
		else if (32'(ws) > WINDOW_MAX) c = CW'(WINDOW_MAX);
		else c = CW'(ws);
		return c;
	endfunction

	state_t state_q, state_d;

	// Configuration
	logic [CW-1:0] cap_q;
	logic [15:0]   expire_q;

	// Latched transaction
	logic [31:0] st_q, rt_q;
	logic        match_q;
	logic [CW-1:0] idx_q, lost_q;

	// Pending queue ring
	logic [PAW-1:0] ph_q;
	logic [CW-1:0]  pc_q;

	// History ring: newest and oldest entries mirrored in registers
	logic [HAW-1:0] hh_q;
	logic [CW-1:0]  hc_q;
	hist_ent_t      nw_q, old_q;

	// Counters and totals
	logic [31:0] sent_q, recv_q, loss_q;
	logic [63:0] tot_q, sqtot_q;
	logic [15:0] low_q, high_q;

	// Receive arithmetic pipeline
	logic [15:0] rtt_s1;
	logic [31:0] sq_s1;

	// RAM ports
	logic           p_we;
	logic [PAW-1:0] p_waddr, p_raddr;
	logic [31:0]    p_wdata, p_rdata;
	logic           h_we;
	logic [HAW-1:0] h_waddr, h_raddr;
	hist_ent_t      h_wdata, h_rdata;
	logic [95:0]    h_rbits;

	logic [31:0]    age, diff;
	logic           expired, rtt_bad, hdrop;
	logic [HAW-1:0] newest;
	logic           out_free;
	logic [31:0]    hc_ext;

	prs_ram #(.WIDTH(32), .DEPTH(WINDOW_MAX), .AW(PAW)) u_pend (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	prs_ram #(.WIDTH(96), .DEPTH(HD), .AW(HAW)) u_hist (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rbits)
	);

	assign h_rdata  = hist_ent_t'(h_rbits);
	assign age      = st_q - p_rdata;
	assign expired  = age >= {16'd0, expire_q};
	assign diff     = rt_q - st_q;
	assign rtt_bad  = diff[31] || (diff >= {16'd0, expire_q});
	assign newest   = hidx(hh_q, hc_q - ONE);
	assign hdrop    = hc_q >= (cap_q + ONE);
	assign out_free = !out_valid || out_ready;
	assign hc_ext   = 32'(hc_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					priority case (cmd)
						CMD_SEND:  state_d = (pc_q == '0) ? S_SEND_PUSH : S_SEND_RD;
						CMD_RECV:  state_d = (pc_q == '0) ? S_DONE : S_RECV_RD;
						CMD_CLEAR: state_d = S_CLEAR;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_SEND_RD:  state_d = S_SEND_CHK;
			S_SEND_CHK: begin
				if (expired && pc_q > ONE) state_d = S_SEND_RD;
				else state_d = S_SEND_PUSH;
			end
			S_SEND_PUSH: state_d = S_DONE;
			S_RECV_RD:   state_d = S_RECV_CHK;
			S_RECV_CHK: begin
				if (p_rdata == st_q) begin
					state_d = (idx_q + ONE < pc_q) ? S_SHIFT_RD : S_RECV_EVAL;
				end else begin
					state_d = (idx_q + ONE < pc_q) ? S_RECV_RD : S_DONE;
				end
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: state_d = (idx_q + TWO < pc_q) ? S_SHIFT_RD : S_RECV_EVAL;
			S_RECV_EVAL: state_d = rtt_bad ? S_DONE : S_RECV_UPD;
			S_RECV_UPD:  state_d = (hdrop && hc_q != TWO) ? S_HIST_RD : S_DONE;
			S_HIST_RD:   state_d = S_DONE;
			S_CLEAR:     state_d = S_DONE;
			S_DONE:      state_d = out_free ? S_IDLE : S_DONE;
			default:     state_d = S_IDLE;
		endcase
	end

	// RAM controls and handshake
	always_comb begin
		in_ready = (state_q == S_IDLE);
		p_we     = 1'b0;
		p_waddr  = pidx(ph_q, pc_q);
		p_wdata  = st_q;
		p_raddr  = ph_q;
		h_we     = 1'b0;
		h_waddr  = newest;
		h_wdata  = nw_q;
		// next-oldest entry, taken as the new oldest when the ring drops one
		h_raddr  = hidx(hh_q, ONE);
		unique case (state_q)
			S_SEND_PUSH: begin
				p_we = 1'b1;
			end
			S_RECV_RD:  p_raddr = pidx(ph_q, idx_q);
			S_SHIFT_RD: p_raddr = pidx(ph_q, idx_q + ONE);
			S_SHIFT_WR: begin
				p_we    = 1'b1;
				p_waddr = pidx(ph_q, idx_q);
				p_wdata = p_rdata;
			end
			S_RECV_UPD: begin
				// retire the current newest entry into the ring
				h_we = 1'b1;
				if (hc_q == ONE) h_wdata.lost = '0;
			end
			default: begin
			end
		endcase
	end

	// Datapath and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= clamp_cap(WINDOW_RESET);
			expire_q <= EXPIRE_RESET;
			ph_q     <= '0;
			pc_q     <= '0;
			hh_q     <= '0;
			hc_q     <= ONE;
			nw_q     <= '0;
			sent_q   <= '0;
			recv_q   <= '0;
			loss_q   <= '0;
			tot_q    <= '0;
			sqtot_q  <= '0;
			low_q    <= '0;
			high_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						if (cfg_index == CFG_WINDOW_SIZE) begin
							cap_q   <= clamp_cap(cfg_wdata[4:0]);
							ph_q    <= '0;
							pc_q    <= '0;
							hh_q    <= '0;
							hc_q    <= ONE;
							nw_q    <= '0;
							sent_q  <= '0;
							recv_q  <= '0;
							loss_q  <= '0;
							tot_q   <= '0;
							sqtot_q <= '0;
							low_q   <= '0;
							high_q  <= '0;
						end else begin
							expire_q <= cfg_wdata;
						end
					end
					if (in_valid) begin
						st_q    <= send_time;
						rt_q    <= recv_time;
						match_q <= 1'b0;
						idx_q   <= '0;
						lost_q  <= '0;
					end
				end
				S_SEND_CHK: begin
					if (expired) begin
						ph_q   <= pidx(ph_q, ONE);
						pc_q   <= pc_q - ONE;
						lost_q <= lost_q + ONE;
						loss_q <= loss_q + 32'd1;
					end
				end
				S_SEND_PUSH: begin
					// full queue: drop oldest, the new time takes its slot count
					if (pc_q != '0 && pc_q >= cap_q) begin
						ph_q       <= pidx(ph_q, ONE);
						loss_q     <= loss_q + 32'd1;
						nw_q.lost  <= nw_q.lost + 32'(lost_q) + 32'd1;
					end else begin
						pc_q       <= pc_q + ONE;
						nw_q.lost  <= nw_q.lost + 32'(lost_q);
					end
					sent_q <= sent_q + 32'd1;
				end
				S_RECV_CHK: begin
					if (p_rdata == st_q) begin
						match_q <= 1'b1;
						if (!(idx_q + ONE < pc_q)) pc_q <= pc_q - ONE;
					end else begin
						idx_q <= idx_q + ONE;
					end
				end
				S_SHIFT_WR: begin
					idx_q <= idx_q + ONE;
					if (!(idx_q + TWO < pc_q)) pc_q <= pc_q - ONE;
				end
				S_RECV_EVAL: begin
					if (rtt_bad) begin
						nw_q.lost <= nw_q.lost + 32'd1;
						loss_q    <= loss_q + 32'd1;
					end else begin
						rtt_s1 <= diff[15:0];
						sq_s1  <= diff[15:0] * diff[15:0];
						recv_q <= recv_q + 32'd1;
					end
				end
				S_RECV_UPD: begin
					if (recv_q == 32'd1) begin
						low_q  <= rtt_s1;
						high_q <= rtt_s1;
					end else begin
						if (rtt_s1 > high_q) high_q <= rtt_s1;
						if (rtt_s1 < low_q) low_q <= rtt_s1;
					end
					tot_q   <= tot_q + 64'(rtt_s1);
					sqtot_q <= sqtot_q + 64'(sq_s1);
					nw_q.rtt_sum <= nw_q.rtt_sum + 32'(rtt_s1);
					nw_q.sq_sum  <= nw_q.sq_sum + sq_s1;
					if (hc_q == ONE) begin
						old_q <= '{rtt_sum: nw_q.rtt_sum, sq_sum: nw_q.sq_sum, lost: '0};
					end
					if (hdrop) begin
						hh_q <= hidx(hh_q, ONE);
						if (hc_q == TWO) old_q <= nw_q;
					end else begin
						hc_q <= hc_q + ONE;
					end
				end
				S_HIST_RD: old_q <= h_rdata;
				S_CLEAR: begin
					if (pc_q != '0) begin
						pc_q <= '0;
						if (sent_q >= 32'(pc_q)) begin
							sent_q <= sent_q - 32'(pc_q);
						end else begin
							sent_q <= '0;
							loss_q <= '0;
							recv_q <= '0;
						end
					end
				end
				S_DONE: begin
					if (out_free) out_valid <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Result register: hold the snapshot until taken
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			matched        <= match_q;
			sent_total     <= sent_q;
			received_total <= recv_q;
			lost_total     <= loss_q;
			rtt_min_ms     <= low_q;
			rtt_max_ms     <= high_q;
			rtt_sum_ms     <= tot_q;
			rtt_sq_sum     <= sqtot_q;
			if (hc_q == ONE) begin
				win_rtt_sum    <= '0;
				win_rtt_sq_sum <= '0;
				win_lost       <= nw_q.lost;
			end else begin
				win_rtt_sum    <= nw_q.rtt_sum - old_q.rtt_sum;
				win_rtt_sq_sum <= nw_q.sq_sum - old_q.sq_sum;
				win_lost       <= nw_q.lost - old_q.lost;
			end
			win_entries <= hc_ext[4:0];
		end
	end

endmodule
